### rtl/mcdb_pkg.sv
// Shared types and constants for the multichannel input debouncer.
`timescale 1ns / 1ps

package mcdb_pkg;

   localparam int PIN_W      = 32;
   localparam int CNT_W      = 16;
   localparam int CHAN_CNT_W = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam int CHANNELS_DEFAULT = 32;

   // Register indexes on the csr channel
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_DELAY  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNELS_IN_USE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLED         = 2'd2;

   // Register reset values
   localparam logic [CNT_W-1:0]      DELAY_RESET    = 16'd1000;
   localparam logic [CHAN_CNT_W-1:0] IN_USE_RESET   = 6'd0;
   localparam logic                  ENABLED_RESET  = 1'b0;

   // Request kinds
   localparam logic KIND_TICK    = 1'b0;
   localparam logic KIND_CAPTURE = 1'b1;

   // Per-lane command for one accepted item
   typedef struct packed {
      logic tick;
      logic capture;
   } lane_cmd_type;

   // Per-lane result: debounced level after the item, and whether it flipped
   typedef struct packed {
      logic level;
      logic flip;
   } lane_result_type;

endpackage

### rtl/mcdb_lane.sv
// One debounce lane: counter and debounced bit for a single channel.
`timescale 1ns / 1ps

module mcdb_lane
   import mcdb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  lane_cmd_type     cmd,
   input  logic             pin,
   input  logic [CNT_W-1:0] delay,
   input  logic [CNT_W-1:0] limit,
   output lane_result_type  result
);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             level_ff;
   logic             level_in;
   logic             flip;

   always_comb begin
      logic [CNT_W-1:0] c;
      c    = count_ff;
      flip = 1'b0;
      if (cmd.tick) begin
         if (pin != level_ff) begin
            if (c == '0) begin
               c = CNT_W'(1);
            end
            if (c > delay) begin
               flip = 1'b1;
               c    = '0;
            end
         end
         // running counter keeps advancing until it saturates at the limit
         if (c != '0 && c < limit) begin
            c = c + CNT_W'(1);
         end
      end else if (cmd.capture) begin
         flip = pin & ~level_ff;
      end
      count_in = c;
      level_in = level_ff ^ flip;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         level_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         level_ff <= level_in;
      end
   end

   assign result.level = level_in;
   assign result.flip  = flip;

endmodule

### rtl/mcdb_merge.sv
// Merge stage: gathers lane results into the registered response.
`timescale 1ns / 1ps

module mcdb_merge
   import mcdb_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  lane_result_type       lanes [CHANNELS],
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [PIN_W-1:0]      rsp_debounced_levels,
   output logic [PIN_W-1:0]      rsp_changed_mask
);

   logic             valid_ff;
   logic [PIN_W-1:0] levels_ff;
   logic [PIN_W-1:0] levels_in;
   logic [PIN_W-1:0] changed_ff;
   logic [PIN_W-1:0] changed_in;

   always_comb begin
      levels_in  = '0;
      changed_in = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         levels_in[i]  = lanes[i].level;
         changed_in[i] = lanes[i].flip;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         levels_ff  <= levels_in;
         changed_ff <= changed_in;
      end
   end

   assign rsp_valid            = valid_ff;
   assign rsp_debounced_levels = levels_ff;
   assign rsp_changed_mask     = changed_ff;

endmodule

### rtl/multichannel_input_debouncer.sv
// Top level of the multichannel input debouncer.
`timescale 1ns / 1ps
//
// Debounces up to CHANNELS input pins. Each req_ transfer carries a kind
// (tick or capture) and a 32-bit pin word; each one yields exactly one rsp_
// transfer with the debounced levels after the item and the mask of bits
// that flipped during it.
// Registers go in on the csr_ channel (index 0 debounce_delay, 1
// channels_in_use, 2 enabled); csr_ready is always high and writes to
// other indexes are dropped. Write them only while the block is idle.
// The response is valid the cycle after the req_ transfer. Throughput: one
// item per cycle while rsp_ready is high. As an item is taken, each active
// lane updates counter and bit; the merge register then holds the result.
// req_ready is high whenever the response register is empty or being
// drained in the same cycle, so a stalled receiver (rsp_ready low) holds
// the pending response and blocks only the next request.
// Reset (synchronous) clears all counters and debounced bits, drops any
// pending response, and restores delay 1000, zero channels, disabled.
// While disabled, items pass through: the response shows the current
// debounced levels with an empty change mask.

module multichannel_input_debouncer
   import mcdb_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_kind,
   input  logic [PIN_W-1:0]      req_pin_levels,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [PIN_W-1:0]      rsp_debounced_levels,
   output logic [PIN_W-1:0]      rsp_changed_mask,
   // register write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic [CNT_W-1:0]      delay_ff;
   logic [CHAN_CNT_W-1:0] in_use_ff;
   logic                  enabled_ff;
   logic [CNT_W:0]        limit_wide;
   logic [CNT_W-1:0]      limit;
   logic                  accept;
   lane_result_type       lane_res [CHANNELS];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff   <= DELAY_RESET;
         in_use_ff  <= IN_USE_RESET;
         enabled_ff <= ENABLED_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_DEBOUNCE_DELAY:  delay_ff   <= csr_data[CNT_W-1:0];
            CSR_CHANNELS_IN_USE: in_use_ff  <= csr_data[CHAN_CNT_W-1:0];
            CSR_ENABLED:         enabled_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Counter ceiling delay+2, clipped so the 16-bit counter never wraps
   assign limit_wide = {1'b0, delay_ff} + (CNT_W+1)'(2);
   assign limit      = limit_wide[CNT_W] ? '1 : limit_wide[CNT_W-1:0];

   assign req_ready = !rsp_valid || rsp_ready;
   assign accept    = req_valid && req_ready;

   for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
      localparam logic [CHAN_CNT_W-1:0] LANE_IDX = CHAN_CNT_W'(i);
      lane_cmd_type cmd;
      logic         active;

      // channels_in_use above CHANNELS leaves every lane active
      assign active      = in_use_ff > LANE_IDX;
      assign cmd.tick    = accept && enabled_ff && active && (req_kind == KIND_TICK);
      assign cmd.capture = accept && enabled_ff && active && (req_kind == KIND_CAPTURE);

      mcdb_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .cmd    (cmd),
         .pin    (req_pin_levels[i]),
         .delay  (delay_ff),
         .limit  (limit),
         .result (lane_res[i])
      );
   end

   mcdb_merge #(
      .CHANNELS (CHANNELS)
   ) u_merge (
      .clock                (clock),
      .reset                (reset),
      .load                 (accept),
      .lanes                (lane_res),
      .rsp_ready            (rsp_ready),
      .rsp_valid            (rsp_valid),
      .rsp_debounced_levels (rsp_debounced_levels),
      .rsp_changed_mask     (rsp_changed_mask)
   );

endmodule
